// ----- rtl/qep_pkg.sv -----
// Shared types, constants and the phase transition table of the quadrature decoder.
`default_nettype none
package qep_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int POS_W = 31;
  localparam int TIME_W = 32;
  localparam int PPT_W = 11;
  localparam int MOD_W = 10;
  localparam int DEG_W = 9;
  localparam int ANGLE_W = 40;
  localparam int DIV_W = 31;
  localparam int ITER_W = $clog2(DIV_W + 1);
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [PPT_W-1:0] PPT_RESET = PPT_W'(24);
  localparam logic [PPT_W-1:0] PPT_MIN = PPT_W'(1);
  localparam logic [PPT_W-1:0] PPT_MAX = PPT_W'(1024);
  localparam logic [DEG_W-1:0] DEG_FULL = DEG_W'(360);

  // Register index, taken from the word address bit of the APB address.
  localparam logic REG_PPT = 1'b0;

  localparam logic [1:0] PHASE_LOW = 2'b00;
  localparam logic [1:0] PHASE_HIGH = 2'b11;

  // Half-step change indexed by {last phases, new phases}.
  localparam logic signed [1:0] STEP_TABLE [16] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0,
    2'sd1, 2'sd0, 2'sd0, -2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1,
    2'sd0, 2'sd1, -2'sd1, 2'sd0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP_GO,
    ST_STEP_WAIT,
    ST_POS_GO,
    ST_POS_WAIT,
    ST_FIX,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [ITER_W-1:0] iters;
    logic [PPT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [PPT_W-1:0] remainder;
  } div_rsp_t;

  typedef struct packed {
    logic              detent_event;
    logic [POS_W-1:0]  detent;
    logic [TIME_W-1:0] interval;
  } trk_t;

endpackage
`default_nettype wire

// ----- rtl/qep_if.sv -----
// Valid/ready channel interfaces for encoder requests and position results.
`default_nettype none
interface qep_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic                                pin_a;
  logic                                pin_b;
  logic signed [qep_pkg::POS_W-1:0]    new_position;
  logic        [qep_pkg::TIME_W-1:0]   time_now;

  modport source (
    output valid, req_type, pin_a, pin_b, new_position, time_now,
    input  ready
  );
  modport sink (
    input  valid, req_type, pin_a, pin_b, new_position, time_now,
    output ready
  );
endinterface

interface qep_out_if;
  logic                                valid;
  logic                                ready;
  logic                                detent_event;
  logic signed [qep_pkg::POS_W-1:0]    detent_position;
  logic        [qep_pkg::MOD_W-1:0]    modulo_position;
  logic signed [qep_pkg::ANGLE_W-1:0]  angle_degrees;
  logic        [qep_pkg::DEG_W-1:0]    modulo_angle_degrees;
  logic        [qep_pkg::TIME_W-1:0]   detent_interval;

  modport source (
    output valid, detent_event, detent_position, modulo_position, angle_degrees,
           modulo_angle_degrees, detent_interval,
    input  ready
  );
  modport sink (
    input  valid, detent_event, detent_position, modulo_position, angle_degrees,
           modulo_angle_degrees, detent_interval,
    output ready
  );
endinterface
`default_nettype wire

// ----- rtl/qep_tracker.sv -----
// Phase transition decoding, half-step counter, detent position and time stamps.
`default_nettype none
module qep_tracker #(
  parameter int COUNT_BITS = qep_pkg::COUNT_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               accept_i,
  input  wire logic                               req_type_i,
  input  wire logic                               pin_a_i,
  input  wire logic                               pin_b_i,
  input  wire logic signed [qep_pkg::POS_W-1:0]   new_position_i,
  input  wire logic        [qep_pkg::TIME_W-1:0]  time_now_i,
  output qep_pkg::trk_t                           trk_o
);

  logic [COUNT_BITS-1:0]          count_q, count_d;
  logic [1:0]                     last_q, last_d;
  logic [qep_pkg::POS_W-1:0]      detent_q, detent_d;
  logic [qep_pkg::TIME_W-1:0]     time_q, time_d;
  logic [qep_pkg::TIME_W-1:0]     prior_q, prior_d;
  logic                           event_q, event_d;

  logic [1:0]                     phase;
  logic signed [1:0]              step;
  logic [COUNT_BITS-1:0]          count_step;
  logic signed [COUNT_BITS-2:0]   half_step;
  logic signed [COUNT_BITS-1:0]   np_ext;

  assign phase      = {pin_b_i, pin_a_i};
  assign step       = qep_pkg::STEP_TABLE[{last_q, phase}];
  assign count_step = count_q + COUNT_BITS'(step);
  assign half_step  = count_step[COUNT_BITS-1:1];
  assign np_ext     = COUNT_BITS'(new_position_i);

  always_comb begin
    count_d  = count_q;
    last_d   = last_q;
    detent_d = detent_q;
    time_d   = time_q;
    prior_d  = prior_q;
    event_d  = event_q;
    if (accept_i) begin
      event_d = 1'b0;
      if (req_type_i) begin
        // The half-step bit survives a position load.
        count_d  = {np_ext[COUNT_BITS-2:0], count_q[0]};
        detent_d = new_position_i;
      end else if (phase != last_q) begin
        count_d = count_step;
        last_d  = phase;
        if (phase == qep_pkg::PHASE_LOW || phase == qep_pkg::PHASE_HIGH) begin
          detent_d = qep_pkg::POS_W'(half_step);
          prior_d  = time_q;
          time_d   = time_now_i;
          event_d  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      last_q   <= qep_pkg::PHASE_HIGH;
      detent_q <= '0;
      time_q   <= '0;
      prior_q  <= '0;
      event_q  <= 1'b0;
    end else begin
      count_q  <= count_d;
      last_q   <= last_d;
      detent_q <= detent_d;
      time_q   <= time_d;
      prior_q  <= prior_d;
      event_q  <= event_d;
    end
  end

  assign trk_o.detent_event = event_q;
  assign trk_o.detent       = detent_q;
  assign trk_o.interval     = time_q - prior_q;

endmodule
`default_nettype wire

// ----- rtl/qep_divider.sv -----
// Restoring divider, one quotient bit per cycle, shared by the angle step and the modulo.
`default_nettype none
module qep_divider (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire qep_pkg::div_req_t   req_i,
  output qep_pkg::div_rsp_t        rsp_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [qep_pkg::ITER_W-1:0]         cnt_q, cnt_d;
  logic [qep_pkg::PPT_W-1:0]          rem_q, rem_d;
  logic [qep_pkg::DIV_W-1:0]          quo_q, quo_d;
  logic [qep_pkg::PPT_W-1:0]          div_q, div_d;

  logic [qep_pkg::PPT_W:0]            trial;
  logic [qep_pkg::PPT_W:0]            diff;
  logic                               fits;

  assign trial = {rem_q, quo_q[qep_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (req_i.start) begin
      // Short dividends arrive left-aligned so that fewer iterations suffice.
      busy_d = 1'b1;
      cnt_d  = req_i.iters;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[qep_pkg::PPT_W-1:0] : trial[qep_pkg::PPT_W-1:0];
      quo_d = {quo_q[qep_pkg::DIV_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == qep_pkg::ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule
`default_nettype wire

// ----- rtl/quadrature_encoder_position.sv -----
// From an input transfer to a valid result, the shared bit-serial divider runs 9 iterations for the
// angle step and 31 for the modulo, around the sequencing steps (two divider starts, two captures,
// the sign fold and the output load). A new item is taken only once the previous one has been
// loaded into the output register; input ready is high only while the sequencer is idle.
// Reset: asynchronous, active low; counter and detent position clear, phases read as both high,
// positions per turn becomes 24.
`default_nettype none
module quadrature_encoder_position #(
  parameter int COUNT_BITS = qep_pkg::COUNT_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  qep_in_if.sink                                  in_s,
  qep_out_if.source                               out_m,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [qep_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [qep_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [qep_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                    pready
);

  qep_pkg::state_e                 state_q, state_d;
  qep_pkg::div_req_t               div_req;
  qep_pkg::div_rsp_t               div_rsp;
  qep_pkg::trk_t                   trk;

  logic [qep_pkg::PPT_W-1:0]       ppt_q;
  logic [qep_pkg::PPT_W-1:0]       n_eff;
  logic                            reg_sel;

  logic                            in_xfer;
  logic                            out_free;
  logic                            load_step, load_rem, load_mod, load_out;

  logic [qep_pkg::DEG_W-1:0]       step_q;
  logic [qep_pkg::PPT_W-1:0]       rem_q;
  logic [qep_pkg::MOD_W-1:0]       mod_q;
  logic                            neg;
  logic [qep_pkg::POS_W-1:0]       mag;
  logic [qep_pkg::PPT_W-1:0]       mod_fix;
  logic signed [qep_pkg::ANGLE_W-1:0] angle_full;
  logic [qep_pkg::DEG_W+qep_pkg::MOD_W-1:0] mod_angle_full;

  logic                            out_valid_q;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == qep_pkg::REG_PPT;
  assign prdata  = reg_sel ? qep_pkg::APB_DATA_W'(ppt_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppt_q <= qep_pkg::PPT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      ppt_q <= pwdata[qep_pkg::PPT_W-1:0];
    end
  end

  always_comb begin
    if (ppt_q == '0) begin
      n_eff = qep_pkg::PPT_MIN;
    end else if (ppt_q > qep_pkg::PPT_MAX) begin
      n_eff = qep_pkg::PPT_MAX;
    end else begin
      n_eff = ppt_q;
    end
  end

  assign in_s.ready = state_q == qep_pkg::ST_IDLE;
  assign in_xfer    = in_s.valid && in_s.ready;
  assign out_free   = !out_valid_q || out_m.ready;

  qep_tracker #(
    .COUNT_BITS(COUNT_BITS)
  ) u_tracker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_xfer),
    .req_type_i     (in_s.req_type),
    .pin_a_i        (in_s.pin_a),
    .pin_b_i        (in_s.pin_b),
    .new_position_i (in_s.new_position),
    .time_now_i     (in_s.time_now),
    .trk_o          (trk)
  );

  qep_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // The modulo works on the magnitude; a negative position folds back into 0..n-1.
  assign neg     = trk.detent[qep_pkg::POS_W-1];
  assign mag     = neg ? qep_pkg::POS_W'(-trk.detent) : trk.detent;
  assign mod_fix = (neg && rem_q != '0) ? n_eff - rem_q : rem_q;

  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = mag;
    div_req.iters    = qep_pkg::ITER_W'(qep_pkg::DIV_W);
    div_req.divisor  = n_eff;
    load_step        = 1'b0;
    load_rem         = 1'b0;
    load_mod         = 1'b0;
    load_out         = 1'b0;
    unique case (state_q)
      qep_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = qep_pkg::ST_STEP_GO;
        end
      end
      qep_pkg::ST_STEP_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {qep_pkg::DEG_FULL, (qep_pkg::DIV_W - qep_pkg::DEG_W)'(0)};
        div_req.iters    = qep_pkg::ITER_W'(qep_pkg::DEG_W);
        state_d          = qep_pkg::ST_STEP_WAIT;
      end
      qep_pkg::ST_STEP_WAIT: begin
        if (div_rsp.done) begin
          load_step = 1'b1;
          state_d   = qep_pkg::ST_POS_GO;
        end
      end
      qep_pkg::ST_POS_GO: begin
        div_req.start = 1'b1;
        state_d       = qep_pkg::ST_POS_WAIT;
      end
      qep_pkg::ST_POS_WAIT: begin
        if (div_rsp.done) begin
          load_rem = 1'b1;
          state_d  = qep_pkg::ST_FIX;
        end
      end
      qep_pkg::ST_FIX: begin
        load_mod = 1'b1;
        state_d  = qep_pkg::ST_OUT;
      end
      qep_pkg::ST_OUT: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = qep_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = qep_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qep_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_step) begin
      step_q <= div_rsp.quotient[qep_pkg::DEG_W-1:0];
    end
    if (load_rem) begin
      rem_q <= div_rsp.remainder;
    end
    if (load_mod) begin
      mod_q <= mod_fix[qep_pkg::MOD_W-1:0];
    end
  end

  assign angle_full     = $signed({1'b0, step_q}) * $signed(trk.detent);
  assign mod_angle_full = step_q * mod_q;

  // Output register: the result waits here while the next item may already be taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_m.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_m.detent_event         <= trk.detent_event;
      out_m.detent_position      <= trk.detent;
      out_m.modulo_position      <= mod_q;
      out_m.angle_degrees        <= angle_full;
      out_m.modulo_angle_degrees <= mod_angle_full[qep_pkg::DEG_W-1:0];
      out_m.detent_interval      <= trk.interval;
    end
  end

  assign out_m.valid = out_valid_q;

`ifndef NO_ASSERTIONS
  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == qep_pkg::ST_IDLE |-> !div_rsp.busy)
    else $error("divider busy while the sequencer is idle");

  a_xfer_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == qep_pkg::ST_STEP_GO)
    else $error("input transfer did not start the sequence");

  a_mod_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_m.valid |-> {1'b0, out_m.modulo_position} < n_eff)
    else $error("modulo position not below positions per turn");

  a_mod_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_m.valid |-> out_m.modulo_angle_degrees < qep_pkg::DEG_FULL)
    else $error("modulo angle reaches a full turn");
`endif

endmodule
`default_nettype wire
